/* hw/rtl/v3n_pkg.sv */
// Shared types and constants for the vector3_normalize pipeline.
// No dependencies.
package v3n_pkg;
  localparam int unsigned CoordW = 32;
  localparam int unsigned MagW   = 32;
  localparam int unsigned SqW    = 64;
  localparam int unsigned SumW   = 66;
  localparam int unsigned RootW  = 33;
  localparam int unsigned NormW  = 32;
  localparam int unsigned DivNumW = 48;
  localparam int unsigned QuotW  = 48;

  typedef logic signed [CoordW-1:0] coord_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
  } point_t;

  typedef struct packed {
    logic [MagW-1:0] x;
    logic [MagW-1:0] y;
    logic [MagW-1:0] z;
  } mag_t;

  function automatic logic [MagW-1:0] mag32(input coord_t c);
    logic [MagW-1:0] u;
    u = MagW'(c);
    return c[CoordW-1] ? (~u + MagW'(1)) : u;
  endfunction
endpackage

/* hw/rtl/v3n_sumsq.sv */
// Sum of squares of the three coordinate magnitudes, two register stages.
// Depends on v3n_pkg.
module v3n_sumsq (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     valid_i,
  input  v3n_pkg::point_t          point_i,
  output logic                     valid_o,
  output v3n_pkg::point_t          point_o,
  output logic [v3n_pkg::SumW-1:0] sum_o
);
  logic                     v1_q, v2_q;
  v3n_pkg::point_t          p1_q, p2_q;
  logic [v3n_pkg::SqW-1:0]  sx_q, sy_q, sz_q;
  logic [v3n_pkg::SumW-1:0] sum_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    p1_q  <= point_i;
    sx_q  <= v3n_pkg::SqW'(v3n_pkg::mag32(point_i.x)) * v3n_pkg::SqW'(v3n_pkg::mag32(point_i.x));
    sy_q  <= v3n_pkg::SqW'(v3n_pkg::mag32(point_i.y)) * v3n_pkg::SqW'(v3n_pkg::mag32(point_i.y));
    sz_q  <= v3n_pkg::SqW'(v3n_pkg::mag32(point_i.z)) * v3n_pkg::SqW'(v3n_pkg::mag32(point_i.z));
    p2_q  <= p1_q;
    sum_q <= v3n_pkg::SumW'(sx_q) + v3n_pkg::SumW'(sy_q) + v3n_pkg::SumW'(sz_q);
  end

  assign valid_o = v2_q;
  assign point_o = p2_q;
  assign sum_o   = sum_q;
endmodule

/* hw/rtl/v3n_sqrt.sv */
// Pipelined restoring floor square root, one result bit per stage.
// Depends on v3n_pkg.
module v3n_sqrt (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      valid_i,
  input  v3n_pkg::point_t           point_i,
  input  logic [v3n_pkg::SumW-1:0]  sum_i,
  output logic                      valid_o,
  output v3n_pkg::point_t           point_o,
  output logic [v3n_pkg::NormW-1:0] norm_o
);
  localparam int unsigned N = v3n_pkg::RootW;
  localparam int unsigned RemW = v3n_pkg::RootW + 2;

  logic [N:0]                      v_q;
  v3n_pkg::point_t                 p_q   [N+1];
  logic [v3n_pkg::SumW-1:0]        val_q [N+1];
  logic [RemW-1:0]                 rem_q [N+1];
  logic [v3n_pkg::RootW-1:0]       root_q[N+1];

  always_comb begin
    v_q[0]    = valid_i;
    p_q[0]    = point_i;
    val_q[0]  = sum_i;
    rem_q[0]  = '0;
    root_q[0] = '0;
  end

  for (genvar s = 0; s < N; s++) begin : g_stage
    logic [RemW-1:0] trial_d, rem_d;
    logic            ok_d;
    always_comb begin
      rem_d   = {rem_q[s][RemW-3:0], val_q[s][v3n_pkg::SumW-1 -: 2]};
      trial_d = {root_q[s], 2'b01};
      ok_d    = rem_d >= trial_d;
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[s+1] <= 1'b0;
      end else begin
        v_q[s+1] <= v_q[s];
      end
    end
    always_ff @(posedge clk_i) begin
      p_q[s+1]    <= p_q[s];
      val_q[s+1]  <= {val_q[s][v3n_pkg::SumW-3:0], 2'b00};
      rem_q[s+1]  <= ok_d ? (rem_d - trial_d) : rem_d;
      root_q[s+1] <= {root_q[s][v3n_pkg::RootW-2:0], ok_d};
    end
  end

  assign valid_o = v_q[N];
  assign point_o = p_q[N];
  assign norm_o  = root_q[N][v3n_pkg::NormW-1:0];
endmodule

/* hw/rtl/v3n_div.sv */
// Pipelined restoring divider for the three projected magnitudes, one bit a stage.
// Depends on v3n_pkg.
module v3n_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      valid_i,
  input  v3n_pkg::point_t           point_i,
  input  logic [v3n_pkg::NormW-1:0] norm_i,
  input  logic                      small_i,
  output logic                      valid_o,
  output v3n_pkg::point_t           point_o,
  output logic                      small_o
);
  localparam int unsigned N = v3n_pkg::DivNumW;
  localparam int unsigned RW = v3n_pkg::NormW + 1;

  logic [N:0]                v_q;
  logic [N:0]                sm_q;
  v3n_pkg::point_t           p_q [N+1];
  logic [v3n_pkg::NormW-1:0] d_q [N+1];
  logic [N-1:0]              num_q [N+1][3];
  logic [RW-1:0]             rem_q [N+1][3];

  always_comb begin
    v_q[0]  = valid_i;
    sm_q[0] = small_i;
    p_q[0]  = point_i;
    d_q[0]  = norm_i;
    num_q[0][0] = {v3n_pkg::mag32(point_i.x), 16'h0000};
    num_q[0][1] = {v3n_pkg::mag32(point_i.y), 16'h0000};
    num_q[0][2] = {v3n_pkg::mag32(point_i.z), 16'h0000};
    for (int k = 0; k < 3; k++) rem_q[0][k] = '0;
  end

  for (genvar s = 0; s < N; s++) begin : g_stage
    logic [RW-1:0] r_d [3];
    logic          ok_d [3];
    always_comb begin
      for (int k = 0; k < 3; k++) begin
        r_d[k]  = {rem_q[s][k][RW-2:0], num_q[s][k][N-1]};
        ok_d[k] = r_d[k] >= RW'(d_q[s]);
      end
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[s+1] <= 1'b0;
      end else begin
        v_q[s+1] <= v_q[s];
      end
    end
    always_ff @(posedge clk_i) begin
      sm_q[s+1] <= sm_q[s];
      p_q[s+1]  <= p_q[s];
      d_q[s+1]  <= d_q[s];
      for (int k = 0; k < 3; k++) begin
        rem_q[s+1][k] <= ok_d[k] ? (r_d[k] - RW'(d_q[s])) : r_d[k];
        num_q[s+1][k] <= {num_q[s][k][N-2:0], ok_d[k]};
      end
    end
  end

  function automatic v3n_pkg::coord_t sgn(input logic neg, input logic [N-1:0] q);
    logic [v3n_pkg::CoordW-1:0] t;
    t = q[v3n_pkg::CoordW-1:0];
    return neg ? v3n_pkg::coord_t'(~t + 1'b1) : v3n_pkg::coord_t'(t);
  endfunction

  always_comb begin
    valid_o = v_q[N];
    small_o = sm_q[N];
    if (sm_q[N]) begin
      point_o = p_q[N];
    end else begin
      point_o.x = sgn(p_q[N].x[v3n_pkg::CoordW-1], num_q[N][0]);
      point_o.y = sgn(p_q[N].y[v3n_pkg::CoordW-1], num_q[N][1]);
      point_o.z = sgn(p_q[N].z[v3n_pkg::CoordW-1], num_q[N][2]);
    end
  end
endmodule

/* hw/rtl/vector3_normalize.sv */
// Top level of the vector3_normalize block: threshold register and pipeline.
// Depends on v3n_pkg, v3n_sumsq, v3n_sqrt and v3n_div.
//
// Usage: drive x_in_i, y_in_i, z_in_i (signed Q16.16) with start high for one cycle
// to issue a transaction; busy is always low, so a point may enter every cycle.
// Each point yields one result on x_out_o, y_out_o, z_out_o and too_small_o, marked
// by done_o for exactly one cycle, once the point has passed through every register
// stage. The 84 register stages are: two stages form the sum of squares, 33 stages
// the bit-serial square root, one stage compares the norm with the threshold and
// 48 stages the three parallel dividers, one quotient bit each.
// Throughput is one point per cycle.
// too_small_o is set when the norm is zero or below min_norm; the point then
// passes unchanged. cfg_we_i writes min_norm from cfg_wdata_i.
// Reset clears every valid bit in flight and sets min_norm to 1.
// The receiver cannot stall: results are presented and dropped in one cycle.
module vector3_normalize (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start,
  output logic                    busy,
  input  logic                    cfg_we_i,
  input  logic [31:0]             cfg_wdata_i,
  input  logic signed [31:0]      x_in_i,
  input  logic signed [31:0]      y_in_i,
  input  logic signed [31:0]      z_in_i,
  output logic                    done_o,
  output logic signed [31:0]      x_out_o,
  output logic signed [31:0]      y_out_o,
  output logic signed [31:0]      z_out_o,
  output logic                    too_small_o
);
  logic [31:0]                     min_norm_q;
  logic                            sq_v, rt_v, dv_v, cmp_v_q, sm_q;
  v3n_pkg::point_t                 in_p, sq_p, rt_p, cmp_p_q, dv_p;
  logic [v3n_pkg::SumW-1:0]        sum;
  logic [v3n_pkg::NormW-1:0]       norm, norm_q;
  logic                            dv_sm;

  assign busy = 1'b0;
  assign in_p = '{x: x_in_i, y: y_in_i, z: z_in_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_norm_q <= 32'd1;
      cmp_v_q    <= 1'b0;
    end else begin
      if (cfg_we_i) min_norm_q <= cfg_wdata_i;
      cmp_v_q <= rt_v;
    end
  end

  always_ff @(posedge clk_i) begin
    cmp_p_q <= rt_p;
    norm_q  <= norm;
    sm_q    <= (norm == '0) || (norm < min_norm_q);
  end

  v3n_sumsq u_sumsq (
    .clk_i, .rst_ni, .valid_i(start), .point_i(in_p),
    .valid_o(sq_v), .point_o(sq_p), .sum_o(sum)
  );

  v3n_sqrt u_sqrt (
    .clk_i, .rst_ni, .valid_i(sq_v), .point_i(sq_p), .sum_i(sum),
    .valid_o(rt_v), .point_o(rt_p), .norm_o(norm)
  );

  v3n_div u_div (
    .clk_i, .rst_ni, .valid_i(cmp_v_q), .point_i(cmp_p_q),
    .norm_i(sm_q ? v3n_pkg::NormW'(1) : norm_q), .small_i(sm_q),
    .valid_o(dv_v), .point_o(dv_p), .small_o(dv_sm)
  );

  assign done_o      = dv_v;
  assign x_out_o     = dv_p.x;
  assign y_out_o     = dv_p.y;
  assign z_out_o     = dv_p.z;
  assign too_small_o = dv_sm;
endmodule

/* tb/vector3_normalize_tb.sv */
// Self-checking testbench for vector3_normalize: projection onto the unit sphere.
// Predicts each transaction in place and checks the results in order.
// Depends on v3n_pkg and the vector3_normalize RTL.
module vector3_normalize_tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef v3n_pkg::coord_t coord_t;

  typedef struct {
    coord_t x;
    coord_t y;
    coord_t z;
    logic   flag;
  } unit_pt_t;

  localparam int unsigned WatchLimit = 2000;
  localparam int unsigned Latency    = 84;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic        cfg_we_i = 1'b0;
  logic [31:0] cfg_wdata_i = '0;
  coord_t      x_in_i = '0, y_in_i = '0, z_in_i = '0;
  logic        done_o;
  coord_t      x_out_o, y_out_o, z_out_o;
  logic        too_small_o;

  unit_pt_t    pend_mem [256];
  logic [7:0]  wr_idx = '0;
  logic [7:0]  rd_idx = '0;
  logic [31:0] thresh;
  int unsigned sender_idle_pct;
  int unsigned mismatches = 0;
  int unsigned idle_cycles = 0;

  vector3_normalize uut (
    .clk_i, .rst_ni, .start, .busy, .cfg_we_i, .cfg_wdata_i,
    .x_in_i, .y_in_i, .z_in_i, .done_o, .x_out_o, .y_out_o, .z_out_o, .too_small_o
  );

  always #10 clk_i = ~clk_i;

  function automatic logic [31:0] magnitude(input coord_t c);
    return c[31] ? 32'(-c) : 32'(c);
  endfunction

  function automatic logic [31:0] floor_root(input logic [63:0] v);
    logic [63:0] res;
    logic [63:0] bitv;
    res = '0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res[31:0];
  endfunction

  function automatic coord_t scale_coord(input coord_t c, input logic [31:0] norm);
    logic [63:0] q;
    q = {16'd0, magnitude(c), 16'd0} / {32'd0, norm};
    if (c[31]) q = -q;
    return q[31:0];
  endfunction

  function automatic unit_pt_t project_point(input coord_t x, y, z, input logic [31:0] thr);
    unit_pt_t    r;
    logic [63:0] sum;
    logic [31:0] norm;
    sum = 64'(magnitude(x)) * 64'(magnitude(x)) + 64'(magnitude(y)) * 64'(magnitude(y))
        + 64'(magnitude(z)) * 64'(magnitude(z));
    norm = floor_root(sum);
    if (norm == 0 || norm < thr) begin
      r = '{x, y, z, 1'b1};
    end else begin
      r = '{scale_coord(x, norm), scale_coord(y, norm), scale_coord(z, norm), 1'b0};
    end
    return r;
  endfunction

  task automatic send_point(input coord_t x, y, z);
    while ($urandom_range(99) < sender_idle_pct) begin
      start = 1'b0;
      @(negedge clk_i);
    end
    start = 1'b1;
    x_in_i = x;
    y_in_i = y;
    z_in_i = z;
    do @(posedge clk_i); while (busy);
    pend_mem[wr_idx] = project_point(x, y, z, thresh);
    wr_idx = wr_idx + 8'd1;
    @(negedge clk_i);
  endtask

  task automatic drain_and_write(input logic [31:0] value);
    start = 1'b0;
    while (wr_idx != rd_idx) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_wdata_i = value;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    thresh = value;
  endtask

  function automatic coord_t rand_coord(input int unsigned kind);
    case (kind)
      0: return coord_t'($urandom());
      1: return coord_t'($urandom_range(0, 512)) - 256;
      2: return coord_t'($urandom_range(0, 32'h0004_0000)) - 32'h0002_0000;
      default: return coord_t'($urandom_range(0, 32'h0200_0000)) - 32'h0100_0000;
    endcase
  endfunction

  task automatic test_extremes();
    coord_t mx, mn;
    mx = 32'sh7fff_ffff;
    mn = 32'sh8000_0000;
    send_point(0, 0, 0);
    send_point(1, 0, 0);
    send_point(-1, 0, 0);
    send_point(0, 32'sh0001_0000, 0);
    send_point(0, 0, -32'sh0001_0000);
    send_point(mx, mx, mx);
    send_point(mn, mn, mn);
    send_point(mx, mn, 0);
    send_point(mn, 0, 0);
    send_point(0, mx, 0);
    send_point(3, 4, 0);
    send_point(-3, -4, 12);
    send_point(mn, mx, mn);
    send_point(32'sh0000_ffff, -32'sh0000_ffff, 32'sh0000_ffff);
    send_point(-1, -1, -1);
  endtask

  task automatic test_threshold(input logic [31:0] value);
    drain_and_write(value);
    send_point(0, 0, 0);
    send_point(coord_t'(value), 0, 0);
    send_point(coord_t'(value - 1), 0, 0);
    send_point(0, -coord_t'(value), 0);
    send_point(0, 0, coord_t'(value + 1));
  endtask

  task automatic test_random(input int unsigned count, input int unsigned idle_pct);
    int unsigned kind;
    sender_idle_pct = idle_pct;
    repeat (count) begin
      kind = $urandom_range(0, 3);
      send_point(rand_coord(kind), rand_coord(kind), rand_coord(kind));
    end
  endtask

  always @(posedge clk_i) begin
    unit_pt_t e;
    if ((start && !busy) || done_o) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchLimit) begin
      $display("tb: failure");
      $finish;
    end
    if (done_o) begin
      if (rd_idx == wr_idx) begin
        mismatches <= mismatches + 1;
        if (mismatches < 10) $display("unexpected transaction: %h %h %h %b",
                                      x_out_o, y_out_o, z_out_o, too_small_o);
      end else begin
        e = pend_mem[rd_idx];
        rd_idx <= rd_idx + 8'd1;
        if (e.x !== x_out_o || e.y !== y_out_o || e.z !== z_out_o ||
            e.flag !== too_small_o) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10)
            $display("mismatch: exp %h %h %h %b got %h %h %h %b", e.x, e.y, e.z, e.flag,
                     x_out_o, y_out_o, z_out_o, too_small_o);
        end
      end
    end
  end

  initial begin
    thresh = 32'd1;
    sender_idle_pct = 8;
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_extremes();
    test_threshold(32'd0);
    test_random(250, 8);
    test_threshold(32'hffff_ffff);
    test_random(100, 68);
    test_threshold(32'h0001_0000);
    test_random(150, 68);
    test_threshold($urandom_range(1, 32'h0100_0000));
    test_random(250, 0);
    test_threshold(32'd1);
    start = 1'b0;
    while (wr_idx != rd_idx) @(negedge clk_i);
    repeat (Latency + 16) @(negedge clk_i);
    if (mismatches == 0 && wr_idx == rd_idx) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule
